// File: src/read_write_hazard_tracker_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the read/write hazard tracker
// Shared property wrappers, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef READ_WRITE_HAZARD_TRACKER_UNIT_DEFINES_SVH
`define READ_WRITE_HAZARD_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define RWHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RWHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/rwht_pkg.sv
// ---------------------------------------------------------------------------
// Read/write hazard tracker package
// Field widths, defaults and the item types shared by the tracker modules.
// ---------------------------------------------------------------------------
package rwht_pkg;

  // Fixed field widths.
  localparam int unsigned TASK_W     = 5;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned OUT_MASK_W = 32;

  // Parameter defaults.
  localparam int unsigned MAX_TASKS_DEF       = 32;
  localparam int unsigned COMPONENT_SLOTS_DEF = 64;

  // One input item.
  typedef struct packed {
    logic              graph_start;
    logic [TASK_W-1:0] task_index;
    logic [SLOT_W-1:0] component_slot;
    logic              read_only;
    logic              last_access;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [TASK_W-1:0]     task_out;
    logic [OUT_MASK_W-1:0] depends_mask;
  } out_item_t;

  // Control for one table update.
  typedef struct packed {
    logic              fresh;     // table and pending mask count as cleared
    logic              in_range;  // slot exists in the table
    logic              rd;        // read-only access
    logic [TASK_W-1:0] task_idx;
  } upd_ctrl_t;

endpackage

// File: src/rwht_table.sv
// ---------------------------------------------------------------------------
// Tracker table memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module rwht_table #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 38
) (
  input  logic          clk_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/rwht_update.sv
// ---------------------------------------------------------------------------
// Tracker entry update
// Computes the dependencies of one access and the new table entry.
// ---------------------------------------------------------------------------
module rwht_update #(
  parameter  int unsigned MAX_TASKS = 32,
  localparam int unsigned MaskW     = (MAX_TASKS < 32) ? MAX_TASKS : 32
) (
  input  rwht_pkg::upd_ctrl_t          ctrl_i,
  input  logic                         old_wv_i,
  input  logic [rwht_pkg::TASK_W-1:0]  old_wt_i,
  input  logic [MaskW-1:0]             old_readers_i,
  input  logic [MaskW-1:0]             pending_i,
  output logic                         new_wv_o,
  output logic [rwht_pkg::TASK_W-1:0]  new_wt_o,
  output logic [MaskW-1:0]             new_readers_o,
  output logic [MaskW-1:0]             pending_o
);

  import rwht_pkg::*;

  // One-hot bit of a task; tasks beyond the mask width are dropped.
  function automatic logic [MaskW-1:0] tbit(input logic [TASK_W-1:0] t);
    logic [MaskW-1:0] b;
    b = '0;
    if (32'(t) < MaskW) begin
      b = MaskW'(1) << t;
    end
    return b;
  endfunction

  logic             base_wv;
  logic [TASK_W-1:0] base_wt;
  logic [MaskW-1:0] base_readers;
  logic [MaskW-1:0] base_pending;
  logic [MaskW-1:0] deps;

  // After a graph start the entry and the pending mask read as cleared.
  assign base_wv      = ctrl_i.fresh ? 1'b0 : old_wv_i;
  assign base_wt      = ctrl_i.fresh ? '0 : old_wt_i;
  assign base_readers = ctrl_i.fresh ? '0 : old_readers_i;
  assign base_pending = ctrl_i.fresh ? '0 : pending_i;

  // A read joins the readers; a write takes over the slot.
  always_comb begin
    deps = base_wv ? tbit(base_wt) : '0;
    if (ctrl_i.rd) begin
      new_wv_o      = base_wv;
      new_wt_o      = base_wt;
      new_readers_o = base_readers | tbit(ctrl_i.task_idx);
    end else begin
      deps          = deps | base_readers;
      new_wv_o      = 1'b1;
      new_wt_o      = ctrl_i.task_idx;
      new_readers_o = '0;
    end
    pending_o = ctrl_i.in_range ? (base_pending | deps) : base_pending;
  end

endmodule

// File: src/read_write_hazard_tracker_unit.sv
// ---------------------------------------------------------------------------
// Read/write hazard tracker
// Per component slot, keeps the last writer and the readers since that
// write, and reports each task's dependency mask on its last access.
// ---------------------------------------------------------------------------
//  Channel | Direction | Handshake              | Payload
//  in      | input     | in_valid_i, in_ready_o | in_item_i  (in_item_t)
//  out     | output    | out_valid_o, out_ready_i | out_item_o (out_item_t)
//
// Sustains one item per cycle unless a sweep runs or a stalled output holds
// the stage; the table read-modify-write is one memory read at accept and
// one write as the item leaves the stage, with a bypass of that write.
// A result is registered as its last-access item leaves the stage, which
// waits out the sweep for an item that starts a graph. After reset, and
// after each graph_start item, the table is swept clear; no item is accepted.
// A stalled output holds a last-access item in the stage, and so the input.
// ---------------------------------------------------------------------------
module read_write_hazard_tracker_unit #(
  parameter int unsigned MAX_TASKS       = rwht_pkg::MAX_TASKS_DEF,
  parameter int unsigned COMPONENT_SLOTS = rwht_pkg::COMPONENT_SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rwht_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rwht_pkg::out_item_t out_item_o
);

  import rwht_pkg::*;

  `include "read_write_hazard_tracker_unit_defines.svh"

  localparam int unsigned MaskW = (MAX_TASKS < 32) ? MAX_TASKS : 32;
  localparam int unsigned AW    = $clog2(COMPONENT_SLOTS);
  localparam int unsigned DW    = 1 + TASK_W + MaskW;

  typedef enum logic {ST_CLEAR, ST_RUN} state_e;

  state_e           state_q, state_d;
  logic [AW-1:0]    cnt_q, cnt_d;
  logic             s1_valid_q, s1_valid_d;
  in_item_t         s1_q, s1_d;
  logic [MaskW-1:0] pending_q, pending_d;
  logic             fwd_valid_q, fwd_valid_d;
  logic [AW-1:0]    fwd_addr_q, fwd_addr_d;
  logic [DW-1:0]    fwd_data_q, fwd_data_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic             in_acc;
  logic             s1_adv;
  logic             out_free;
  logic             s1_in_range;
  logic [AW-1:0]    s1_addr;
  logic [DW-1:0]    rdata;
  logic [DW-1:0]    old_entry;
  logic [DW-1:0]    new_entry;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [DW-1:0]    mem_wdata;
  upd_ctrl_t        upd_ctrl;
  logic             new_wv;
  logic [TASK_W-1:0] new_wt;
  logic [MaskW-1:0] new_readers;
  logic [MaskW-1:0] pending_next;

  // Handshakes.
  assign out_free    = !out_valid_q || out_ready_i;
  assign s1_adv      = s1_valid_q && (state_q == ST_RUN) && (!s1_q.last_access || out_free);
  assign in_ready_o  = (state_q == ST_RUN) && (!s1_valid_q || s1_adv);
  assign in_acc      = in_valid_i && in_ready_o;

  // Slot decode for the item in the update stage.
  assign s1_in_range = 32'(s1_q.component_slot) < COMPONENT_SLOTS;
  assign s1_addr     = AW'(s1_q.component_slot);

  // Bypass the write that landed at the same edge as this item's read.
  assign old_entry = (fwd_valid_q && (fwd_addr_q == s1_addr)) ? fwd_data_q : rdata;

  assign upd_ctrl = '{fresh:    s1_q.graph_start,
                      in_range: s1_in_range,
                      rd:       s1_q.read_only,
                      task_idx: s1_q.task_index};

  rwht_update #(
    .MAX_TASKS(MAX_TASKS)
  ) u_update (
    .ctrl_i       (upd_ctrl),
    .old_wv_i     (old_entry[DW-1]),
    .old_wt_i     (old_entry[DW-2 -: TASK_W]),
    .old_readers_i(old_entry[MaskW-1:0]),
    .pending_i    (pending_q),
    .new_wv_o     (new_wv),
    .new_wt_o     (new_wt),
    .new_readers_o(new_readers),
    .pending_o    (pending_next)
  );

  assign new_entry = {new_wv, new_wt, new_readers};

  // Write port: the clearing sweep or the stage's write-back.
  always_comb begin
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_q;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_adv && s1_in_range;
      mem_waddr = s1_addr;
      mem_wdata = new_entry;
    end
  end

  rwht_table #(
    .DEPTH(COMPONENT_SLOTS),
    .AW   (AW),
    .DW   (DW)
  ) u_table (
    .clk_i  (clk_i),
    .re_i   (in_acc),
    .raddr_i(AW'(in_item_i.component_slot)),
    .rdata_o(rdata),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata)
  );

  // Next-state logic for the sequencer, stage, bypass and output register.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    s1_valid_d  = s1_valid_q;
    s1_d        = s1_q;
    pending_d   = pending_q;
    fwd_valid_d = fwd_valid_q;
    fwd_addr_d  = fwd_addr_q;
    fwd_data_d  = fwd_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    unique case (state_q)
      ST_CLEAR: begin
        fwd_valid_d = 1'b0;
        if (cnt_q == AW'(COMPONENT_SLOTS - 1)) begin
          state_d = ST_RUN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_RUN: begin
        if (s1_adv) begin
          s1_valid_d = 1'b0;
          pending_d  = s1_q.last_access ? '0 : pending_next;
          if (s1_in_range) begin
            fwd_valid_d = 1'b1;
            fwd_addr_d  = s1_addr;
            fwd_data_d  = new_entry;
          end
          if (s1_q.last_access) begin
            out_valid_d = 1'b1;
            out_d       = '{task_out:     s1_q.task_index,
                            depends_mask: OUT_MASK_W'(pending_next)};
          end
        end
        if (in_acc) begin
          s1_valid_d = 1'b1;
          s1_d       = in_item_i;
          if (in_item_i.graph_start) begin
            state_d = ST_CLEAR;
            cnt_d   = '0;
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      s1_q        <= '0;
      pending_q   <= '0;
      fwd_valid_q <= 1'b0;
      fwd_addr_q  <= '0;
      fwd_data_q  <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      s1_valid_q  <= s1_valid_d;
      s1_q        <= s1_d;
      pending_q   <= pending_d;
      fwd_valid_q <= fwd_valid_d;
      fwd_addr_q  <= fwd_addr_d;
      fwd_data_q  <= fwd_data_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks on the sequencing of table accesses.
  `RWHT_ASSERT_NEXT(a_start_sweeps, in_acc && in_item_i.graph_start, state_q == ST_CLEAR, "no sweep")
  `RWHT_ASSERT_NOW(a_no_update_in_sweep, state_q == ST_CLEAR, !s1_adv && !fwd_valid_d, "busy sweep")
  `RWHT_ASSERT_NEXT(a_last_emits, s1_adv && s1_q.last_access, out_valid_q, "no result")

endmodule

// File: sim/tb_read_write_hazard_tracker_unit.sv
// ---------------------------------------------------------------------------
// Testbench for the read/write hazard tracker
// Drives a table of directed accesses, then random task graphs with some
// noise, and checks every dependency report against a predictor of the
// per-slot writer and reader tracking, or against a typed directed result.
// ---------------------------------------------------------------------------
module tb_read_write_hazard_tracker_unit;
  import rwht_pkg::*;

  localparam int unsigned NUM_SLOTS    = COMPONENT_SLOTS_DEF;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned NUM_ROWS     = 17;

  // One row of the directed table; the typed result is used where set.
  typedef struct packed {
    logic              start;
    logic [TASK_W-1:0] tsk;
    logic [SLOT_W-1:0] slot;
    logic              rd;
    logic              last;
    logic              typed;
    logic [TASK_W-1:0] exp_task;
    logic [31:0]       exp_mask;
  } access_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  // Shadow of the tracking tables.
  logic              writer_ok [NUM_SLOTS];
  logic [TASK_W-1:0] writer_of [NUM_SLOTS];
  logic [31:0]       readers_since [NUM_SLOTS];
  logic [31:0]       gathered_deps;

  out_item_t   expected_deps_q [$];
  access_row_t directed_rows [NUM_ROWS];
  int unsigned mismatch_cnt = 0;
  bit          calm = 1'b0;

  read_write_hazard_tracker_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Applies one access to the shadow tables; returns 1 when it ends a task.
  function automatic bit resolve_access(input in_item_t acc, output out_item_t rep);
    logic [31:0] deps;
    int          s;
    s = acc.component_slot;
    rep = '0;
    if (acc.graph_start) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        writer_ok[i] = 1'b0;
        writer_of[i] = '0;
        readers_since[i] = '0;
      end
      gathered_deps = '0;
    end
    deps = '0;
    if (writer_ok[s]) deps |= 32'h1 << writer_of[s];
    if (acc.read_only) begin
      readers_since[s] |= 32'h1 << acc.task_index;
    end else begin
      deps |= readers_since[s];
      readers_since[s] = '0;
      writer_ok[s] = 1'b1;
      writer_of[s] = acc.task_index;
    end
    gathered_deps |= deps;
    if (acc.last_access) begin
      rep.task_out = acc.task_index;
      rep.depends_mask = gathered_deps;
      gathered_deps = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Presents one access, waits for it to be taken and records its result.
  task automatic send_access(input in_item_t acc, input bit typed, input out_item_t typed_rep);
    out_item_t rep;
    if (!calm && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= acc;
    do @(posedge clk_i); while (!in_ready_o);
    if (resolve_access(acc, rep)) begin
      if (typed) rep = typed_rep;
      expected_deps_q = {expected_deps_q, rep};
    end
  endtask

  // One random access; small slot pools make hazards frequent.
  function automatic in_item_t random_access(input int unsigned tsk, input int unsigned pool,
                                             input bit last);
    in_item_t acc;
    acc.graph_start    = 1'b0;
    acc.task_index     = tsk[TASK_W-1:0];
    acc.component_slot = ($urandom_range(99) < 80) ? SLOT_W'(pool + $urandom_range(0, 5))
                                                   : SLOT_W'($urandom);
    acc.read_only      = ($urandom_range(99) < 60);
    acc.last_access    = last;
    return acc;
  endfunction

  // Result receiver stalls at random outside the calm stretch.
  always @(posedge clk_i) begin
    out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 8);
  end

  // Compares each taken result with the oldest expected one.
  always @(posedge clk_i) begin : result_check
    out_item_t exp_rep;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_deps_q.size() == 0) begin
        $error("unexpected result: task_out %0d depends_mask %h",
               out_item_o.task_out, out_item_o.depends_mask);
        mismatch_cnt++;
      end else begin
        exp_rep = expected_deps_q.pop_front();
        if (out_item_o.task_out !== exp_rep.task_out) begin
          $error("task_out: expected %0d, actual %0d", exp_rep.task_out, out_item_o.task_out);
          mismatch_cnt++;
        end
        if (out_item_o.depends_mask !== exp_rep.depends_mask) begin
          $error("depends_mask: expected %h, actual %h",
                 exp_rep.depends_mask, out_item_o.depends_mask);
          mismatch_cnt++;
        end
      end
    end
  end

  // Ends a hung run.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_read_write_hazard_tracker_unit NOT OK");
    $finish;
  end

  initial begin : stimulus
    in_item_t    acc;
    out_item_t   rep;
    out_item_t   none;
    int unsigned sent;
    int unsigned ntasks;
    int unsigned nacc;
    int unsigned tsk;
    int unsigned pool;

    none = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      writer_ok[i] = 1'b0;
      writer_of[i] = '0;
      readers_since[i] = '0;
    end
    gathered_deps = '0;

    //                 start task slot rd last typed task mask
    directed_rows = '{
      '{1'b0,  5'd0,  6'd0, 1'b0, 1'b1, 1'b1,  5'd0, 32'h0000_0000}, // first write
      '{1'b0,  5'd1,  6'd0, 1'b1, 1'b1, 1'b1,  5'd1, 32'h0000_0001}, // read after write
      '{1'b0,  5'd2,  6'd0, 1'b1, 1'b1, 1'b1,  5'd2, 32'h0000_0001},
      '{1'b0,  5'd3,  6'd0, 1'b0, 1'b1, 1'b1,  5'd3, 32'h0000_0007}, // write after reads
      '{1'b0, 5'd31, 6'd63, 1'b0, 1'b1, 1'b1, 5'd31, 32'h0000_0000}, // top task and slot
      '{1'b0, 5'd31, 6'd63, 1'b1, 1'b0, 1'b0,  5'd0, 32'h0},         // read, then
      '{1'b0, 5'd31, 6'd63, 1'b0, 1'b1, 1'b0,  5'd0, 32'h0},         // write: own bit
      '{1'b0,  5'd4,  6'd0, 1'b1, 1'b0, 1'b0,  5'd0, 32'h0},         // task changes
      '{1'b0,  5'd5, 6'd63, 1'b1, 1'b1, 1'b0,  5'd0, 32'h0},         // with deps kept
      '{1'b1,  5'd0,  6'd0, 1'b0, 1'b1, 1'b1,  5'd0, 32'h0000_0000}, // graph start
      '{1'b0,  5'd7,  6'd0, 1'b1, 1'b1, 1'b1,  5'd7, 32'h0000_0001},
      '{1'b0,  5'd9,  6'd5, 1'b0, 1'b0, 1'b0,  5'd0, 32'h0},         // double write
      '{1'b0,  5'd9,  6'd5, 1'b0, 1'b1, 1'b0,  5'd0, 32'h0},
      '{1'b0, 5'd16, 6'd42, 1'b1, 1'b1, 1'b1, 5'd16, 32'h0000_0000}, // unwritten slot
      '{1'b0, 5'd10, 6'd21, 1'b0, 1'b0, 1'b0,  5'd0, 32'h0},
      '{1'b0, 5'd21, 6'd21, 1'b1, 1'b1, 1'b0,  5'd0, 32'h0},
      '{1'b1, 5'd31, 6'd63, 1'b1, 1'b1, 1'b1, 5'd31, 32'h0000_0000}  // start on a read
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table.
    foreach (directed_rows[i]) begin
      acc.graph_start    = directed_rows[i].start;
      acc.task_index     = directed_rows[i].tsk;
      acc.component_slot = directed_rows[i].slot;
      acc.read_only      = directed_rows[i].rd;
      acc.last_access    = directed_rows[i].last;
      rep.task_out       = directed_rows[i].exp_task;
      rep.depends_mask   = directed_rows[i].exp_mask;
      send_access(acc, directed_rows[i].typed, rep);
    end

    // Random graphs of well-formed tasks, mixed with loose noise.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = (sent >= 150 && sent < 250);
      if ($urandom_range(99) < 85) begin
        ntasks = $urandom_range(2, 12);
        tsk = ($urandom_range(1) != 0) ? 0 : $urandom_range(0, 31);
        pool = $urandom_range(0, 63);
        for (int t = 0; t < ntasks; t++) begin
          nacc = $urandom_range(1, 4);
          for (int k = 0; k < nacc; k++) begin
            acc = random_access(tsk, pool, k == nacc - 1);
            acc.graph_start = (t == 0 && k == 0 && $urandom_range(99) < 70);
            send_access(acc, 1'b0, none);
            sent++;
          end
          tsk = (tsk + $urandom_range(1, 2)) % 32;
        end
      end else begin
        repeat ($urandom_range(1, 3)) begin
          acc = in_item_t'($urandom);
          acc.graph_start = ($urandom_range(7) == 0);
          send_access(acc, 1'b0, none);
          sent++;
        end
      end
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    while (expected_deps_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && expected_deps_q.size() == 0) begin
      $display("tb_read_write_hazard_tracker_unit OK");
    end else begin
      $display("tb_read_write_hazard_tracker_unit NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/rwht_pkg.sv
src/rwht_table.sv
src/rwht_update.sv
src/read_write_hazard_tracker_unit.sv
sim/tb_read_write_hazard_tracker_unit.sv
